@@ sv/scan_disk_scheduler_assert.svh @@
// assertion macros for the scan disk scheduler
// used by the top level only, no other dependencies
`ifndef SCAN_DISK_SCHEDULER_ASSERT_SVH
`define SCAN_DISK_SCHEDULER_ASSERT_SVH

// same-cycle implication under reset
`define SDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scan disk scheduler check failed");

// next-cycle implication under reset
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scan disk scheduler check failed");

`endif

@@ sv/sds_pkg.sv @@
// shared types and constants of the scan disk scheduler
// no dependencies
package sds_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TRACK_BITS  = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DIST_W      = TRACK_BITS + 1;
  localparam int TT_W        = 9;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [CNT_W-1:0]      DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [TRACK_BITS-1:0] TRACK_MAX = {TRACK_BITS{1'b1}};
  localparam logic [DIST_W-1:0]     SUM_MAX   = {DIST_W{1'b1}};

  localparam logic [TT_W-1:0]       RST_TOTAL_TRACKS = TT_W'(200);
  localparam logic [TRACK_BITS-1:0] RST_START_HEAD   = TRACK_BITS'(100);
  localparam logic                  RST_START_UPWARD = 1'b1;

  typedef enum logic [1:0] {
    REG_TOTAL_TRACKS = 2'd0,
    REG_START_HEAD   = 2'd1,
    REG_START_UPWARD = 2'd2
  } sds_reg_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SERVE
  } sds_state_e;

  typedef struct packed {
    logic [TRACK_BITS-1:0] request_track;
    logic                  last_request;
  } sds_req_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0] served_track;
    logic [DIST_W-1:0]     move_distance;
    logic [DIST_W-1:0]     total_seek;
    logic                  final_service;
    logic                  dropped_any;
  } sds_res_t;

  typedef struct packed {
    logic [TT_W-1:0]       total_tracks;
    logic [TRACK_BITS-1:0] start_head;
    logic                  start_upward;
    logic [TRACK_BITS-1:0] edge_track;
  } sds_cfg_t;

endpackage

@@ sv/sds_cfg.sv @@
// configuration registers of the scan disk scheduler behind an apb-style port
// depends on sds_pkg
module sds_cfg import sds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output sds_cfg_t          cfg_o
);

  logic [TT_W-1:0]       total_tracks_q;
  logic [TRACK_BITS-1:0] start_head_q;
  logic                  start_upward_q;
  logic                  wr_en;
  sds_reg_e              reg_sel;
  logic [TT_W-1:0]       tt_m1;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = sds_reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_tracks_q <= RST_TOTAL_TRACKS;
      start_head_q   <= RST_START_HEAD;
      start_upward_q <= RST_START_UPWARD;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TOTAL_TRACKS: total_tracks_q <= pwdata[TT_W-1:0];
        REG_START_HEAD:   start_head_q   <= pwdata[TRACK_BITS-1:0];
        REG_START_UPWARD: start_upward_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOTAL_TRACKS: prdata = APB_DW'(total_tracks_q);
      REG_START_HEAD:   prdata = APB_DW'(start_head_q);
      REG_START_UPWARD: prdata = APB_DW'(start_upward_q);
      default:          prdata = '0;
    endcase
  end

  // upward sweep edge, clamped to the highest track
  assign tt_m1 = total_tracks_q - TT_W'(1);

  always_comb begin
    cfg_o.total_tracks = total_tracks_q;
    cfg_o.start_head   = start_head_q;
    cfg_o.start_upward = start_upward_q;
    if (total_tracks_q == '0) begin
      cfg_o.edge_track = '0;
    end else if (tt_m1 > TT_W'(TRACK_MAX)) begin
      cfg_o.edge_track = TRACK_MAX;
    end else begin
      cfg_o.edge_track = tt_m1[TRACK_BITS-1:0];
    end
  end

endmodule

@@ sv/scan_disk_scheduler.sv @@
// Track requests are loaded one per cycle, while no batch is in service, into a
// 16-entry request store; the request marked last starts service, and the block
// then returns every stored request in SCAN (elevator) order from the configured
// start track and direction, running to the disk edge before reversing. Each
// served request takes a walk over the store through its single read port, and
// waits while the output side stalls. New requests are taken again once the final
// result has entered the output register. Configuration is read when the last
// request of a batch arrives.
`include "scan_disk_scheduler_assert.svh"

module scan_disk_scheduler import sds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sds_req_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sds_res_t          out_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  sds_cfg_t cfg;

  sds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sds_state_e            state_q, state_d;
  logic [CNT_W-1:0]      count_q, served_q, scan_q;
  logic [QUEUE_DEPTH-1:0] pend_q;
  logic [TRACK_BITS-1:0] head_q, edge_q;
  logic                  up_q;
  logic [DIST_W-1:0]     seek_q;
  logic                  ovf_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [TRACK_BITS-1:0] rd_data_q;
  logic [TRACK_BITS-1:0] mem [QUEUE_DEPTH];
  logic                  a_vld_q, r_vld_q;
  logic [IDX_W-1:0]      a_idx_q, r_idx_q;
  logic [TRACK_BITS-1:0] a_trk_q, r_trk_q;
  logic                  out_valid_q;
  sds_res_t              out_res_q;

  logic                  in_acc, store_en, scan_issue, scan_done, out_free;
  logic                  serve_fire, batch_end, found, is_final, cand_ok;
  logic                  a_take, r_take;
  logic [TRACK_BITS-1:0] sel_trk, turn;
  logic [IDX_W-1:0]      sel_idx;
  logic [DIST_W-1:0]     move_dist;
  logic [DIST_W:0]       sum_raw;
  logic [DIST_W-1:0]     sum_sat;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign store_en    = in_acc && (count_q < DEPTH_CNT);
  assign scan_issue  = (state_q == ST_SCAN) && (scan_q < count_q);
  assign scan_done   = (scan_q == count_q) && !rd_vld_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // candidate checks on the entry read last cycle
  assign cand_ok = rd_vld_q && pend_q[rd_idx_q];
  assign a_take  = cand_ok && (up_q ? (rd_data_q >= head_q) : (rd_data_q <= head_q)) &&
                   (!a_vld_q || (up_q ? (rd_data_q < a_trk_q) : (rd_data_q > a_trk_q)));
  assign r_take  = cand_ok && (up_q ? (rd_data_q <= head_q) : (rd_data_q >= head_q)) &&
                   (!r_vld_q || (up_q ? (rd_data_q > r_trk_q) : (rd_data_q < r_trk_q)));

  // selection and movement for the request being served
  assign found    = a_vld_q || r_vld_q;
  assign sel_trk  = a_vld_q ? a_trk_q : r_trk_q;
  assign sel_idx  = a_vld_q ? a_idx_q : r_idx_q;
  assign turn     = (edge_q > head_q) ? edge_q : head_q;
  assign is_final = (CNT_W'(served_q + CNT_W'(1)) == count_q);

  always_comb begin
    if (a_vld_q) begin
      move_dist = up_q ? DIST_W'(sel_trk - head_q) : DIST_W'(head_q - sel_trk);
    end else if (up_q) begin
      // turning at the upper edge
      move_dist = DIST_W'(turn - head_q) + DIST_W'(turn - sel_trk);
    end else begin
      // turning at track zero
      move_dist = DIST_W'(head_q) + DIST_W'(sel_trk);
    end
  end

  assign sum_raw = {1'b0, seek_q} + {1'b0, move_dist};
  assign sum_sat = sum_raw[DIST_W] ? SUM_MAX : sum_raw[DIST_W-1:0];

  always_comb begin
    state_d    = state_q;
    serve_fire = 1'b0;
    batch_end  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && in_req_i.last_request) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_SERVE;
      end
      ST_SERVE: begin
        if (!found) begin
          batch_end = 1'b1;
          state_d   = ST_LOAD;
        end else if (out_free) begin
          serve_fire = 1'b1;
          batch_end  = is_final;
          state_d    = is_final ? ST_LOAD : ST_SCAN;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      served_q    <= '0;
      scan_q      <= '0;
      pend_q      <= '0;
      head_q      <= RST_START_HEAD;
      edge_q      <= '0;
      up_q        <= RST_START_UPWARD;
      seek_q      <= '0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      a_vld_q     <= 1'b0;
      r_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue;
      if (store_en) begin
        pend_q[count_q[IDX_W-1:0]] <= 1'b1;
        count_q <= count_q + CNT_W'(1);
      end else if (in_acc) begin
        ovf_q <= 1'b1;
      end
      if (in_acc && in_req_i.last_request) begin
        head_q  <= cfg.start_head;
        up_q    <= cfg.start_upward;
        edge_q  <= cfg.edge_track;
        scan_q  <= '0;
        a_vld_q <= 1'b0;
        r_vld_q <= 1'b0;
      end
      if (scan_issue) scan_q <= scan_q + CNT_W'(1);
      if (a_take) a_vld_q <= 1'b1;
      if (r_take) r_vld_q <= 1'b1;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (serve_fire) begin
        pend_q[sel_idx] <= 1'b0;
        head_q      <= sel_trk;
        up_q        <= a_vld_q ? up_q : !up_q;
        seek_q      <= sum_sat;
        served_q    <= served_q + CNT_W'(1);
        scan_q      <= '0;
        a_vld_q     <= 1'b0;
        r_vld_q     <= 1'b0;
        out_valid_q <= 1'b1;
      end
      if (batch_end) begin
        pend_q   <= '0;
        count_q  <= '0;
        served_q <= '0;
        seek_q   <= '0;
        ovf_q    <= 1'b0;
      end
    end
  end

  // request store and best-candidate payload
  always_ff @(posedge clk_i) begin
    if (store_en) mem[count_q[IDX_W-1:0]] <= in_req_i.request_track;
    rd_data_q <= mem[scan_q[IDX_W-1:0]];
    rd_idx_q  <= scan_q[IDX_W-1:0];
    if (a_take) begin
      a_trk_q <= rd_data_q;
      a_idx_q <= rd_idx_q;
    end
    if (r_take) begin
      r_trk_q <= rd_data_q;
      r_idx_q <= rd_idx_q;
    end
    if (serve_fire) begin
      out_res_q.served_track  <= sel_trk;
      out_res_q.move_distance <= move_dist;
      out_res_q.total_seek    <= sum_sat;
      out_res_q.final_service <= is_final;
      out_res_q.dropped_any   <= ovf_q;
    end
  end

  `SDS_ASSERT_NOW(a_pend_balance, clk_i, rst_ni, 1'b1,
    $countones(pend_q) + int'(served_q) == int'(count_q))

  `SDS_ASSERT_NOW(a_read_in_range, clk_i, rst_ni, rd_vld_q,
    CNT_W'(rd_idx_q) < count_q)

  `SDS_ASSERT_NEXT(a_batch_clear, clk_i, rst_ni, serve_fire && is_final,
    count_q == '0 && pend_q == '0 && seek_q == '0 && out_res_q.final_service)

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the scan disk scheduler: track request batches in, served tracks out
// a scoreboard class predicts the scan order and checks each result; depends on sds_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import sds_pkg::*;

  class scan_scoreboard;
    logic [TT_W-1:0]       total_tracks = RST_TOTAL_TRACKS;
    logic [TRACK_BITS-1:0] start_head   = RST_START_HEAD;
    logic                  start_upward = RST_START_UPWARD;
    logic [TRACK_BITS-1:0] track_store [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] pending = '0;
    int                    stored = 0;
    int                    seek_total = 0;
    bit                    overflow = 1'b0;
    sds_res_t              expected_services[$];
    int                    errors = 0;

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(sds_reg_e r, logic [APB_DW-1:0] v);
      case (r)
        REG_TOTAL_TRACKS: total_tracks = v[TT_W-1:0];
        REG_START_HEAD:   start_head   = v[TRACK_BITS-1:0];
        REG_START_UPWARD: start_upward = v[0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_services.size();
    endfunction

    // nearest pending request at or beyond pos in the sweep direction, lower slot wins ties
    function int nearest_ahead(int pos, bit up);
      int best;
      int t;
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!pending[i]) continue;
        t = track_store[i];
        if (up ? (t < pos) : (t > pos)) continue;
        if (best < 0 || (up ? (t < int'(track_store[best])) : (t > int'(track_store[best]))))
          best = i;
      end
      return best;
    endfunction

    function int clip_sum(int v);
      return (v > int'(SUM_MAX)) ? int'(SUM_MAX) : v;
    endfunction

    function void note_request(sds_req_t req);
      int edge_trk;
      int turn_trk;
      int pos;
      int move_dist;
      int t;
      int k;
      bit up;
      sds_res_t res;
      if (stored < QUEUE_DEPTH) begin
        track_store[stored] = req.request_track;
        pending[stored] = 1'b1;
        stored++;
      end else begin
        overflow = 1'b1;
      end
      if (!req.last_request) return;

      edge_trk = (total_tracks == 0) ? 0 : int'(total_tracks) - 1;
      if (edge_trk > int'(TRACK_MAX)) edge_trk = int'(TRACK_MAX);
      pos = start_head;
      up = start_upward;
      while (pending != '0) begin
        k = nearest_ahead(pos, up);
        if (k < 0) begin
          up = !up;
          k = nearest_ahead(pos, up);
          t = track_store[k];
          if (up) begin
            // detour down to track zero
            move_dist = pos + t;
          end else begin
            turn_trk = (edge_trk > pos) ? edge_trk : pos;
            move_dist = (turn_trk - pos) + (turn_trk - t);
          end
        end else begin
          t = track_store[k];
          move_dist = (t > pos) ? t - pos : pos - t;
        end
        pending[k] = 1'b0;
        pos = t;
        seek_total = clip_sum(seek_total + move_dist);
        res.served_track  = TRACK_BITS'(t);
        res.move_distance = DIST_W'(clip_sum(move_dist));
        res.total_seek    = DIST_W'(seek_total);
        res.final_service = (pending == '0);
        res.dropped_any   = overflow;
        expected_services = {expected_services, res};
      end
      stored = 0;
      seek_total = 0;
      overflow = 1'b0;
    endfunction

    task check_result(sds_res_t got);
      sds_res_t want;
      if (expected_services.size() == 0) begin
        report($sformatf("unexpected result, track %0d", got.served_track));
        return;
      end
      want = expected_services.pop_front();
      if (got.served_track !== want.served_track)
        report($sformatf("served_track %0d, want %0d", got.served_track, want.served_track));
      if (got.move_distance !== want.move_distance)
        report($sformatf("move_distance %0d, want %0d (track %0d)",
                         got.move_distance, want.move_distance, want.served_track));
      if (got.total_seek !== want.total_seek)
        report($sformatf("total_seek %0d, want %0d (track %0d)",
                         got.total_seek, want.total_seek, want.served_track));
      if (got.final_service !== want.final_service)
        report($sformatf("final_service %0b, want %0b (track %0d)",
                         got.final_service, want.final_service, want.served_track));
      if (got.dropped_any !== want.dropped_any)
        report($sformatf("dropped_any %0b, want %0b (track %0d)",
                         got.dropped_any, want.dropped_any, want.served_track));
    endtask

    task finish_check();
      if (expected_services.size() != 0)
        report($sformatf("%0d results never arrived", expected_services.size()));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  sds_req_t          in_req_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  sds_res_t          out_res_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scan_scoreboard sb = new();
  int  stall_left = 0;
  bit  rx_steady = 1'b0;
  bit  tx_steady = 1'b0;

  scan_disk_scheduler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: check accepted results, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_res_o);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (rx_steady) begin
        out_stall_i <= 1'b0;
      end else begin
        case (1'b1)
          ($urandom_range(0, 99) < 75): out_stall_i <= 1'b0;
          ($urandom_range(0, 99) < 85): begin
            out_stall_i <= 1'b1;
            stall_left = $urandom_range(0, 2);
          end
          default: begin
            out_stall_i <= 1'b1;
            stall_left = $urandom_range(10, 40);
          end
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic apb_write(sds_reg_e r, logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk_i);
  endtask

  // holds the request until taken; valid stays high when no gap follows
  task automatic send_request(sds_req_t req, int gap);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_batch(logic [TRACK_BITS-1:0] tracks[$], bit settle);
    sds_req_t req;
    int gap;
    for (int i = 0; i < tracks.size(); i++) begin
      req.request_track = tracks[i];
      req.last_request  = (i == tracks.size() - 1);
      gap = pick_gap();
      if (settle && req.last_request && gap == 0) gap = 1;
      send_request(req, gap);
    end
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned tt, int unsigned hd, bit up);
    drain();
    apb_write(REG_TOTAL_TRACKS, APB_DW'(tt));
    apb_write(REG_START_HEAD, APB_DW'(hd));
    apb_write(REG_START_UPWARD, APB_DW'(up));
  endtask

  task automatic random_config();
    int unsigned tt_corner [9] = '{0, 1, 2, 199, 200, 255, 256, 257, 511};
    int unsigned tt;
    int unsigned hd;
    if ($urandom_range(0, 9) < 4) tt = tt_corner[$urandom_range(0, 8)];
    else tt = $urandom_range(1, 256);
    case ($urandom_range(0, 9))
      0: hd = 0;
      1: hd = 255;
      2: hd = (tt == 0) ? 0 : (tt - 1) & 8'hff;
      default: hd = $urandom_range(0, 255);
    endcase
    set_config(tt, hd, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [TRACK_BITS-1:0] pick_track(logic [TRACK_BITS-1:0] earlier[$]);
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 55) return TRACK_BITS'($urandom_range(0, 255));
    if (r < 70) begin
      t = int'(sb.start_head) + int'($urandom_range(0, 6)) - 3;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return TRACK_BITS'(t);
    end
    if (r < 85 && earlier.size() > 0) return earlier[$urandom_range(0, earlier.size() - 1)];
    if (r < 93) return '0;
    return TRACK_MAX;
  endfunction

  initial begin
    logic [TRACK_BITS-1:0] trk[$];
    int items;
    int size;
    int r;
    int action;
    bit settle;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: head on a request, repeated tracks, track past the edge
    trk = '{8'd0, 8'd255, 8'd100, 8'd100};
    send_batch(trk, 1'b1);
    // zero tracks, head at top sweeping down
    set_config(0, 255, 1'b0);
    trk = '{8'd0, 8'd128, 8'd255};
    send_batch(trk, 1'b1);
    // widest disk from track zero; store overflow with a dropped final request
    set_config(256, 0, 1'b1);
    trk.delete();
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) trk = {trk, pick_track(trk)};
    send_batch(trk, 1'b1);

    items = 0;
    while (items < 350) begin
      r = $urandom_range(0, 99);
      if (r < 70) size = $urandom_range(1, 8);
      else if (r < 92) size = $urandom_range(9, QUEUE_DEPTH);
      else size = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
      r = $urandom_range(0, 99);
      action = (r < 20) ? 1 : (r < 28) ? 2 : 0;
      settle = (action != 0) || (items + size >= 350);
      tx_steady = ($urandom_range(0, 99) < 15);
      rx_steady = ($urandom_range(0, 99) < 15);
      trk.delete();
      for (int i = 0; i < size; i++) trk = {trk, pick_track(trk)};
      send_batch(trk, settle);
      items += size;
      if (action == 1) random_config();
      else if (action == 2) drain();
    end

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    sb.finish_check();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
